FILE: design/calendar_date_day_adder_defines.svh
// Assertion macros used by the calendar date day adder checker.
`ifndef CALENDAR_DATE_DAY_ADDER_DEFINES_SVH
`define CALENDAR_DATE_DAY_ADDER_DEFINES_SVH

// Same-cycle implication under reset disable.
`define CDDA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset disable.
`define CDDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cdda_pkg.sv
// Shared widths, codes, types and calendar functions for the date day adder.
`timescale 1ns / 1ps
package cdda_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 20;
    localparam int STATUS_W = 2;
    localparam int CYC_W    = 9;   // year position inside the 400-year cycle

    // Calendar constants
    localparam int YEAR_MAX       = 9999;
    localparam int LEAP_CYCLE     = 400;
    localparam int CENTURY        = 100;
    localparam int DAYS_YEAR      = 365;
    localparam int DAYS_LEAP_YEAR = 366;
    localparam int MONTHS         = 12;
    localparam int FEB            = 2;
    localparam int FEB_LEAP_DAY   = 29;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INVALID  = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    // Command codes
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_ADD  = 1'b1;

    // Datapath micro-operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NOP       = 3'd0;
    localparam t_op OP_LATCH     = 3'd1;
    localparam t_op OP_DAY       = 3'd2;
    localparam t_op OP_YEAR      = 3'd3;
    localparam t_op OP_ADD_DONE  = 3'd4;
    localparam t_op OP_MOD       = 3'd5;
    localparam t_op OP_LOAD_DONE = 3'd6;

    // Datapath condition flags
    typedef struct packed {
        logic is_load;
        logic not_feb29;
        logic year_exit;
        logic day_exit;
        logic acc_lt_cycle;
    } t_flags;

    // Committed date and status of a finished request
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        t_status            status;
    } t_result;

    // Leap year from the year position in the 400-year cycle
    function automatic logic f_leap(input logic [CYC_W-1:0] q);
        logic century;
        century = (q == CYC_W'(CENTURY)) || (q == CYC_W'(2 * CENTURY)) ||
                  (q == CYC_W'(3 * CENTURY));
        return (q[1:0] == 2'b00) && !century;
    endfunction

    // Days in a month
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: design/calendar_date_day_adder.sv
// Top level of the calendar date day adder: handshakes, sequencer, datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  request  | in        | i_valid / o_ready  | i_opcode i_year_in i_month_in i_day_in
//           |           |                    | i_day_count
//  result   | out       | o_valid / i_ready  | o_year_out o_month_out o_day_out o_status
//
//  Load: runs the mod-400 subtract loop on year_in to find its place in the 400-year cycle.
//  Add: skips whole years, then steps single days, one year
//  or one day per cycle in the sequencer loops.
//  One request at a time; o_ready is high while the sequencer sits in its idle step.
//  Reset sets the stored date to year 1, January 1 and clears the result valid flag.
//  A full result register holds the sequencer at its write-back step.
`timescale 1ns / 1ps
module calendar_date_day_adder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic [cdda_pkg::YEAR_W-1:0]     i_year_in,
    input  logic [cdda_pkg::MONTH_W-1:0]    i_month_in,
    input  logic [cdda_pkg::DAY_W-1:0]      i_day_in,
    input  logic [cdda_pkg::COUNT_W-1:0]    i_day_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cdda_pkg::YEAR_W-1:0]     o_year_out,
    output logic [cdda_pkg::MONTH_W-1:0]    o_month_out,
    output logic [cdda_pkg::DAY_W-1:0]      o_day_out,
    output logic [cdda_pkg::STATUS_W-1:0]   o_status
);
    import cdda_pkg::*;

    t_op      op;
    t_flags   flags;
    t_result  result;
    logic     done;
    logic     idle;
    logic     start;
    logic     out_busy;
    logic     r_out_valid;
    t_result  r_out;

    assign o_ready  = idle;
    assign start    = i_valid && idle;
    assign out_busy = r_out_valid && !i_ready;

    cdda_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_busy (out_busy),
        .i_flags    (flags),
        .o_op       (op),
        .o_idle     (idle)
    );

    cdda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_opcode    (i_opcode),
        .i_year_in   (i_year_in),
        .i_month_in  (i_month_in),
        .i_day_in    (i_day_in),
        .i_day_count (i_day_count),
        .o_flags     (flags),
        .o_done      (done),
        .o_result    (result)
    );

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_year_out  = r_out.year;
    assign o_month_out = r_out.month;
    assign o_day_out   = r_out.day;
    assign o_status    = r_out.status;

endmodule

FILE: design/cdda_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module cdda_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_busy,
    input  cdda_pkg::t_flags i_flags,
    output cdda_pkg::t_op   o_op,
    output logic            o_idle
);
    import cdda_pkg::*;

    // Condition select codes
    localparam logic [2:0] C_NO_START  = 3'd0;
    localparam logic [2:0] C_IS_LOAD   = 3'd1;
    localparam logic [2:0] C_NOT_FEB29 = 3'd2;
    localparam logic [2:0] C_YEAR_EXIT = 3'd3;
    localparam logic [2:0] C_DAY_EXIT  = 3'd4;
    localparam logic [2:0] C_OUT_BUSY  = 3'd5;
    localparam logic [2:0] C_ACC_LT    = 3'd6;

    // Step addresses
    localparam logic [2:0] A_IDLE     = 3'd0;
    localparam logic [2:0] A_DISPATCH = 3'd1;
    localparam logic [2:0] A_FEB      = 3'd2;
    localparam logic [2:0] A_YEARS    = 3'd3;
    localparam logic [2:0] A_DAYS     = 3'd4;
    localparam logic [2:0] A_ADD_WB   = 3'd5;
    localparam logic [2:0] A_MOD      = 3'd6;
    localparam logic [2:0] A_LOAD_WB  = 3'd7;

    // Control word: when the condition holds, jump and skip the op;
    // otherwise run the op and go to the next address.
    typedef struct packed {
        t_op        op;
        logic [2:0] cond;
        logic [2:0] jmp;
        logic [2:0] nxt;
    } t_uword;

    function automatic t_uword f_rom(input logic [2:0] a);
        t_uword w;
        unique case (a)
            A_IDLE:     w = '{OP_LATCH,     C_NO_START,  A_IDLE,    A_DISPATCH};
            A_DISPATCH: w = '{OP_NOP,       C_IS_LOAD,   A_MOD,     A_FEB};
            A_FEB:      w = '{OP_DAY,       C_NOT_FEB29, A_YEARS,   A_YEARS};
            A_YEARS:    w = '{OP_YEAR,      C_YEAR_EXIT, A_DAYS,    A_YEARS};
            A_DAYS:     w = '{OP_DAY,       C_DAY_EXIT,  A_ADD_WB,  A_DAYS};
            A_ADD_WB:   w = '{OP_ADD_DONE,  C_OUT_BUSY,  A_ADD_WB,  A_IDLE};
            A_MOD:      w = '{OP_MOD,       C_ACC_LT,    A_LOAD_WB, A_MOD};
            A_LOAD_WB:  w = '{OP_LOAD_DONE, C_OUT_BUSY,  A_LOAD_WB, A_IDLE};
        endcase
        return w;
    endfunction

    logic [2:0] r_pc;
    logic [2:0] n_pc;
    t_uword     word;
    logic       cond_true;

    // Fetch and evaluate the condition
    always_comb begin
        word = f_rom(r_pc);
        unique case (word.cond)
            C_NO_START:  cond_true = !i_start;
            C_IS_LOAD:   cond_true = i_flags.is_load;
            C_NOT_FEB29: cond_true = i_flags.not_feb29;
            C_YEAR_EXIT: cond_true = i_flags.year_exit;
            C_DAY_EXIT:  cond_true = i_flags.day_exit;
            C_OUT_BUSY:  cond_true = i_out_busy;
            C_ACC_LT:    cond_true = i_flags.acc_lt_cycle;
            default:     cond_true = 1'b1;
        endcase
        n_pc = cond_true ? word.jmp : word.nxt;
        o_op = cond_true ? OP_NOP : word.op;
    end

    assign o_idle = (r_pc == A_IDLE);

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: design/cdda_dp.sv
// Date datapath: working date, day count, year-cycle tracking and stored date.
`timescale 1ns / 1ps
module cdda_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdda_pkg::t_op                   i_op,
    input  logic                            i_opcode,
    input  logic [cdda_pkg::YEAR_W-1:0]     i_year_in,
    input  logic [cdda_pkg::MONTH_W-1:0]    i_month_in,
    input  logic [cdda_pkg::DAY_W-1:0]      i_day_in,
    input  logic [cdda_pkg::COUNT_W-1:0]    i_day_count,
    output cdda_pkg::t_flags                o_flags,
    output logic                            o_done,
    output cdda_pkg::t_result               o_result
);
    import cdda_pkg::*;

    localparam int WY_W = YEAR_W + 1;

    // Working registers
    logic               r_is_load;
    logic [WY_W-1:0]    r_y;
    logic [MONTH_W-1:0] r_m;
    logic [DAY_W-1:0]   r_d;
    logic [CYC_W-1:0]   r_q;
    logic [YEAR_W-1:0]  r_acc;
    logic [COUNT_W-1:0] r_n;
    logic               r_over;

    // Stored date
    logic [YEAR_W-1:0]  r_cur_year;
    logic [MONTH_W-1:0] r_cur_month;
    logic [DAY_W-1:0]   r_cur_day;
    logic [CYC_W-1:0]   r_cur_q;

    logic               n_is_load;
    logic [WY_W-1:0]    n_y;
    logic [MONTH_W-1:0] n_m;
    logic [DAY_W-1:0]   n_d;
    logic [CYC_W-1:0]   n_q;
    logic [YEAR_W-1:0]  n_acc;
    logic [COUNT_W-1:0] n_n;
    logic               n_over;
    logic [YEAR_W-1:0]  n_cur_year;
    logic [MONTH_W-1:0] n_cur_month;
    logic [DAY_W-1:0]   n_cur_day;
    logic [CYC_W-1:0]   n_cur_q;
    t_status            res_status;

    logic               leap_now;
    logic [CYC_W-1:0]   q_inc;
    logic [DAY_W-1:0]   mlen;
    logic               month_end;
    logic               roll_year;
    logic [WY_W-1:0]    y_inc;
    logic               inc_over;
    logic [WY_W-1:0]    ds_y;
    logic [MONTH_W-1:0] ds_m;
    logic [DAY_W-1:0]   ds_d;
    logic [CYC_W-1:0]   ds_q;
    logic               has_leap;
    logic [COUNT_W-1:0] ys_n;
    logic [CYC_W-1:0]   q_in;
    logic [DAY_W-1:0]   ld_len;
    logic               ld_ok;

    // Single-day and whole-year step logic
    always_comb begin
        leap_now  = f_leap(r_q);
        q_inc     = (r_q == CYC_W'(LEAP_CYCLE - 1)) ? '0 : r_q + CYC_W'(1);
        mlen      = f_month_len(r_m, leap_now);
        month_end = (r_d >= mlen);
        roll_year = month_end && (r_m >= MONTH_W'(MONTHS));
        y_inc     = r_y + WY_W'(1);
        inc_over  = (y_inc > WY_W'(YEAR_MAX));

        ds_d = month_end ? DAY_W'(1) : r_d + DAY_W'(1);
        ds_m = !month_end ? r_m : (roll_year ? MONTH_W'(1) : r_m + MONTH_W'(1));
        ds_y = roll_year ? y_inc : r_y;
        ds_q = roll_year ? q_inc : r_q;

        // The next Feb 29 lies in this year or the next one
        has_leap = (r_m <= MONTH_W'(FEB)) ? leap_now : f_leap(q_inc);
        ys_n     = r_n - (has_leap ? COUNT_W'(DAYS_LEAP_YEAR) : COUNT_W'(DAYS_YEAR));

        // Load validation
        q_in   = r_acc[CYC_W-1:0];
        ld_len = f_month_len(r_m, f_leap(q_in));
        ld_ok  = (r_y != '0) && (r_y <= WY_W'(YEAR_MAX)) &&
                 (r_m >= MONTH_W'(1)) && (r_m <= MONTH_W'(MONTHS)) &&
                 (r_d >= DAY_W'(1)) && (r_d <= ld_len);
    end

    // Condition flags for the sequencer
    always_comb begin
        o_flags.is_load      = r_is_load;
        o_flags.not_feb29    = !((r_n != '0) && (r_m == MONTH_W'(FEB)) &&
                                 (r_d == DAY_W'(FEB_LEAP_DAY)));
        o_flags.year_exit    = r_over || (r_n < COUNT_W'(DAYS_LEAP_YEAR));
        o_flags.day_exit     = r_over || (r_n == '0);
        o_flags.acc_lt_cycle = (r_acc < YEAR_W'(LEAP_CYCLE));
    end

    // Execute the micro-operation
    always_comb begin
        n_is_load   = r_is_load;
        n_y         = r_y;
        n_m         = r_m;
        n_d         = r_d;
        n_q         = r_q;
        n_acc       = r_acc;
        n_n         = r_n;
        n_over      = r_over;
        n_cur_year  = r_cur_year;
        n_cur_month = r_cur_month;
        n_cur_day   = r_cur_day;
        n_cur_q     = r_cur_q;
        res_status  = ST_OK;
        o_done      = 1'b0;
        unique case (i_op)
            OP_NOP: begin
            end
            OP_LATCH: begin
                n_is_load = (i_opcode == OPC_LOAD);
                n_y       = (i_opcode == OPC_LOAD) ? {1'b0, i_year_in} : {1'b0, r_cur_year};
                n_m       = (i_opcode == OPC_LOAD) ? i_month_in : r_cur_month;
                n_d       = (i_opcode == OPC_LOAD) ? i_day_in : r_cur_day;
                n_q       = r_cur_q;
                n_acc     = i_year_in;
                n_n       = i_day_count;
                n_over    = 1'b0;
            end
            OP_DAY: begin
                n_y    = ds_y;
                n_m    = ds_m;
                n_d    = ds_d;
                n_q    = ds_q;
                n_n    = r_n - COUNT_W'(1);
                n_over = roll_year && inc_over;
            end
            OP_YEAR: begin
                n_y    = y_inc;
                n_q    = q_inc;
                n_n    = ys_n;
                n_over = inc_over;
            end
            OP_MOD: begin
                n_acc = r_acc - YEAR_W'(LEAP_CYCLE);
            end
            OP_ADD_DONE: begin
                o_done = 1'b1;
                if (r_over) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    n_cur_year  = r_y[YEAR_W-1:0];
                    n_cur_month = r_m;
                    n_cur_day   = r_d;
                    n_cur_q     = r_q;
                end
            end
            OP_LOAD_DONE: begin
                o_done = 1'b1;
                if (ld_ok) begin
                    n_cur_year  = r_y[YEAR_W-1:0];
                    n_cur_month = r_m;
                    n_cur_day   = r_d;
                    n_cur_q     = q_in;
                end else begin
                    res_status = ST_INVALID;
                end
            end
            default: begin
            end
        endcase
        o_result.year   = n_cur_year;
        o_result.month  = n_cur_month;
        o_result.day    = n_cur_day;
        o_result.status = res_status;
    end

    // Hold the stored date; reset to year 1, January 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_year  <= YEAR_W'(1);
            r_cur_month <= MONTH_W'(1);
            r_cur_day   <= DAY_W'(1);
            r_cur_q     <= CYC_W'(1);
        end else begin
            r_cur_year  <= n_cur_year;
            r_cur_month <= n_cur_month;
            r_cur_day   <= n_cur_day;
            r_cur_q     <= n_cur_q;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_is_load <= n_is_load;
        r_y       <= n_y;
        r_m       <= n_m;
        r_d       <= n_d;
        r_q       <= n_q;
        r_acc     <= n_acc;
        r_n       <= n_n;
        r_over    <= n_over;
    end

endmodule

FILE: design/cdda_checker.sv
// Port-level checker for the calendar date day adder, bound to the top level.
`timescale 1ns / 1ps
`include "calendar_date_day_adder_defines.svh"
module cdda_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [cdda_pkg::YEAR_W-1:0]     o_year_out,
    input  logic [cdda_pkg::MONTH_W-1:0]    o_month_out,
    input  logic [cdda_pkg::DAY_W-1:0]      o_day_out,
    input  logic [cdda_pkg::STATUS_W-1:0]   o_status
);
    import cdda_pkg::*;

    // Hold a stalled result
    `CDDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_year_out) && $stable(o_month_out) && $stable(o_day_out) && $stable(o_status), "result changed while stalled")

    // Only defined status codes leave the block
    `CDDA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid, o_status == ST_OK || o_status == ST_INVALID || o_status == ST_OVERFLOW, "undefined status code")

    // The output date has a month of 1 to 12, a day of at least 1 and a year of 1 to YEAR_MAX
    `CDDA_ASSERT_IMPL(a_date_range, i_clk, i_rst_n, o_valid, o_month_out >= 4'd1 && o_month_out <= 4'd12 && o_day_out >= 5'd1 && o_year_out >= 14'd1 && o_year_out <= 14'(YEAR_MAX), "stored date out of range")

    // One request in flight: ready drops after an accept
    `CDDA_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken while busy")

endmodule

bind calendar_date_day_adder cdda_checker u_cdda_checker (.*);
